>>> hdl/sopll_pkg.sv
`timescale 1ns / 1ps

package sopll_pkg;

   // Width of the CORDIC x/y datapath: 17-bit folded input times the
   // CORDIC gain (about 1.65) times sqrt(2), plus sign.
   localparam int CORDIC_XW = 19;

   localparam int ATAN_ENTRIES = 24;

   // atan(2^-i) in 32-bit turns.
   localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // 1 / CORDIC gain in Q1.15
   localparam longint INV_GAIN_Q15 = 64'sd19898;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_GAIN = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQ_GAIN  = 4'd1;

   localparam logic [15:0] PHASE_GAIN_RESET = 16'd3277;
   localparam logic [15:0] FREQ_GAIN_RESET  = 16'd20972;

   typedef struct packed {
      logic [15:0] phase_gain;
      logic [15:0] freq_gain;
   } gains_type;

   function automatic logic [15:0] sat16(input longint v);
      logic [15:0] r;
      if (v > 64'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -64'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Rotation-mode CORDIC of a quantized phase; {sin, cos}, cos in the low half.
   // Evaluated at elaboration only, to fill the sine table.
   function automatic logic [31:0] sin_cos_entry(input logic [31:0] q, input int steps);
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      logic   neg;
      z   = longint'(signed'(q));
      x   = INV_GAIN_Q15;
      y   = 64'sd0;
      neg = 1'b0;
      if (z > 64'sd1073741824) begin
         z   = z - 64'sd2147483648;
         neg = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z   = z + 64'sd2147483648;
         neg = 1'b1;
      end
      for (int i = 0; i < steps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 64'sd0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'({32'd0, ATAN_TURNS[i]});
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'({32'd0, ATAN_TURNS[i]});
         end
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      return {sat16(y), sat16(x)};
   endfunction

endpackage

>>> hdl/sopll_csr.sv
`timescale 1ns / 1ps

module sopll_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sopll_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [15:0]                         csr_data,
   output sopll_pkg::gains_type                gains
);

   sopll_pkg::gains_type gains_ff;
   sopll_pkg::gains_type gains_in;

   assign csr_ready = 1'b1;
   assign gains     = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sopll_pkg::CSR_PHASE_GAIN: gains_in.phase_gain = csr_data;
            sopll_pkg::CSR_FREQ_GAIN:  gains_in.freq_gain  = csr_data;
            default:                   gains_in = gains_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.phase_gain <= sopll_pkg::PHASE_GAIN_RESET;
         gains_ff.freq_gain  <= sopll_pkg::FREQ_GAIN_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

>>> hdl/sopll_vector.sv
`timescale 1ns / 1ps

// Pipelined vectoring CORDIC: output angle in 32-bit turns, two iterations per stage.
module sopll_vector #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [15:0] in_i,
   input  logic signed [15:0] in_q,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_angle
);

   localparam int XW = sopll_pkg::CORDIC_XW;
   localparam int NS = (CORDIC_STEPS + 1) / 2;

   logic                 valid_ff [NS+1];
   logic                 valid_in [NS+1];
   logic                 en       [NS+1];
   logic signed [XW-1:0] x_ff     [NS+1];
   logic signed [XW-1:0] x_in     [NS+1];
   logic signed [XW-1:0] y_ff     [NS+1];
   logic signed [XW-1:0] y_in     [NS+1];
   logic [31:0]          z_ff     [NS+1];
   logic [31:0]          z_in     [NS+1];
   logic                 zero_ff  [NS+1];
   logic                 zero_in  [NS+1];

   // Stage enables: a stage loads when empty or when its item moves on.
   always_comb begin
      en[NS] = !valid_ff[NS] || out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[NS];
   assign out_angle = zero_ff[NS] ? 32'd0 : z_ff[NS];

   always_comb begin
      logic signed [XW-1:0] xe;
      logic signed [XW-1:0] ye;
      logic signed [XW-1:0] xa;
      logic signed [XW-1:0] ya;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic [31:0]          za;

      // Fold the left half-plane onto the right by a half turn.
      xe = {{(XW-16){in_i[15]}}, in_i};
      ye = {{(XW-16){in_q[15]}}, in_q};
      valid_in[0] = in_valid;
      zero_in[0]  = (in_i == 16'sd0) && (in_q == 16'sd0);
      if (in_i[15]) begin
         x_in[0] = -xe;
         y_in[0] = -ye;
         z_in[0] = 32'h8000_0000;
      end else begin
         x_in[0] = xe;
         y_in[0] = ye;
         z_in[0] = 32'd0;
      end

      for (int s = 0; s < NS; s++) begin
         xa = x_ff[s];
         ya = y_ff[s];
         za = z_ff[s];
         for (int j = 0; j < 2; j++) begin
            if (2 * s + j < CORDIC_STEPS) begin
               dx = ya >>> (2 * s + j);
               dy = xa >>> (2 * s + j);
               if (!ya[XW-1]) begin
                  xa = xa + dx;
                  ya = ya - dy;
                  za = za + sopll_pkg::ATAN_TURNS[2 * s + j];
               end else begin
                  xa = xa - dx;
                  ya = ya + dy;
                  za = za - sopll_pkg::ATAN_TURNS[2 * s + j];
               end
            end
         end
         valid_in[s+1] = valid_ff[s];
         zero_in[s+1]  = zero_ff[s];
         x_in[s+1]     = xa;
         y_in[s+1]     = ya;
         z_in[s+1]     = za;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en[k]) begin
            valid_ff[k] <= valid_in[k];
         end
         if (en[k]) begin
            zero_ff[k]  <= zero_in[k];
            x_ff[k]     <= x_in[k];
            y_ff[k]     <= y_in[k];
            z_ff[k]     <= z_in[k];
         end
      end
   end

endmodule

>>> hdl/sopll_sine_rom.sv
`timescale 1ns / 1ps

// Sine/cosine table with registered read; {sin, cos}, cos in the low half.
module sopll_sine_rom #(
   parameter int TABLE_BITS   = 10,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [TABLE_BITS-1:0] addr,
   output logic [31:0]           rd_data
);

   localparam int DEPTH = 1 << TABLE_BITS;

   function automatic logic [DEPTH-1:0][31:0] build_rom();
      logic [DEPTH-1:0][31:0] rom;
      logic [31:0]            q;
      for (int k = 0; k < DEPTH; k++) begin
         q      = 32'(k) << (32 - TABLE_BITS);
         rom[k] = sopll_pkg::sin_cos_entry(q, CORDIC_STEPS);
      end
      return rom;
   endfunction

   localparam logic [DEPTH-1:0][31:0] ROM_DATA = build_rom();

   logic [31:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ROM_DATA[addr];
      end
   end

endmodule

>>> hdl/sopll_loop.sv
`timescale 1ns / 1ps

// Loop filter, oscillator state and result register.
module sopll_loop #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sopll_pkg::gains_type gains,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [31:0]          in_angle,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [15:0]          out_i,
   output logic [15:0]          out_q,
   output logic [31:0]          out_error,
   output logic [31:0]          out_freq
);

   logic        valid_ff;
   logic [31:0] nco_phase_ff;
   logic [31:0] nco_phase_in;
   logic [31:0] freq_ff;
   logic [31:0] freq_in;
   logic [31:0] err_ff;
   logic [31:0] err_in;
   logic        en;
   logic        load;
   logic [31:0] rom_data;

   logic signed [48:0] prop_prod;
   logic signed [48:0] intg_prod;
   logic        [32:0] freq_sum;

   assign en       = !valid_ff || out_ready;
   assign load     = en && in_valid;
   assign in_ready = en;

   always_comb begin
      err_in    = in_angle - nco_phase_ff;
      intg_prod = $signed({1'b0, gains.freq_gain}) * $signed(err_in);
      prop_prod = $signed({1'b0, gains.phase_gain}) * $signed(err_in);
      freq_sum  = {freq_ff[31], freq_ff} + {{8{intg_prod[48]}}, intg_prod[48:24]};
      // Clamp the frequency at the signed 32-bit limits.
      if (freq_sum[32] != freq_sum[31]) begin
         freq_in = freq_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         freq_in = freq_sum[31:0];
      end
      nco_phase_in = nco_phase_ff + prop_prod[47:16] + freq_in;
   end

   // Read the oscillator output at the phase before this item's update.
   sopll_sine_rom #(
      .TABLE_BITS   (SINE_TABLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (load),
      .addr    (nco_phase_ff[31 -: SINE_TABLE_BITS]),
      .rd_data (rom_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         nco_phase_ff <= 32'd0;
         freq_ff      <= 32'd0;
      end else begin
         if (en) begin
            valid_ff <= in_valid;
         end
         if (load) begin
            nco_phase_ff <= nco_phase_in;
            freq_ff      <= freq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= err_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_i     = rom_data[15:0];
   assign out_q     = rom_data[31:16];
   assign out_error = err_ff;
   assign out_freq  = freq_ff;

endmodule

>>> hdl/second_order_phase_locked_loop.sv
`timescale 1ns / 1ps

// Second-order digital PLL on a complex Q1.15 sample stream.
// req_*: one I/Q sample per item. rsp_*: one result per sample, carrying the
//   oscillator cos/sin at the phase before the update, the wrapped phase
//   error (2^31 = pi) and the updated frequency (turns/sample * 2^32).
// csr_*: gain writes, index 0 = phase gain (Q0.16), 1 = freq gain (x 2^-24);
//   other indexes are ignored. Write only while no item is in flight.
// Throughput: one item per cycle while rsp_tready stays high. The vectoring CORDIC is pipelined at two
//   iterations per stage; the loop filter closes its feedback in a single
//   register stage, so consecutive samples follow back to back.
// Path from an accepted sample to rsp_tvalid: the input register, the CORDIC
//   stages and the result register, in that order.
// Reset: clears oscillator phase and frequency, empties the pipeline and
//   restores default gains. The sine table is a constant ROM, no fill.
// Stall: each stage holds while the stage after it is full, so bubbles
//   collapse; with rsp_tready low the pipeline keeps accepting until full.
module second_order_phase_locked_loop #(
   parameter int CORDIC_STEPS    = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // in_i[15:0], in_q[31:16]
   // result out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [95:0]                       rsp_tdata,  // out_i[15:0], out_q[31:16],
                                                         // loop_error[63:32],
                                                         // freq_estimate[95:64]
   // gain writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sopll_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                       csr_data
);

   sopll_pkg::gains_type gains;

   logic signed [15:0] in_i;
   logic signed [15:0] in_q;
   logic               ang_valid;
   logic               ang_ready;
   logic [31:0]        ang_turns;
   logic [15:0]        out_i;
   logic [15:0]        out_q;
   logic [31:0]        loop_error;
   logic [31:0]        freq_estimate;

   assign in_i = req_tdata[15:0];
   assign in_q = req_tdata[31:16];

   sopll_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .gains     (gains)
   );

   // Measure the input phase.
   sopll_vector #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_vector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_i      (in_i),
      .in_q      (in_q),
      .out_valid (ang_valid),
      .out_ready (ang_ready),
      .out_angle (ang_turns)
   );

   // Compare against the oscillator, advance it, hold the result.
   sopll_loop #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_loop (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .in_angle  (ang_turns),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_i     (out_i),
      .out_q     (out_q),
      .out_error (loop_error),
      .out_freq  (freq_estimate)
   );

   assign rsp_tdata = {freq_estimate, loop_error, out_q, out_i};

endmodule

>>> hdl/sopll_checker.sv
`timescale 1ns / 1ps

module sopll_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [95:0]                       rsp_tdata,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A draining output never blocks the input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   // Gain writes are never refused out of reset.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("gain write refused");

endmodule

bind second_order_phase_locked_loop sopll_checker u_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int STEPS        = 16;
   localparam int TABLE_BITS   = 10;
   localparam int PIPE_LATENCY = (STEPS + 1) / 2 + 1;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic signed [31:0] FREQ_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] FREQ_MIN = 32'sh80000000;
   localparam longint UNIT_AMPLITUDE = 64'sd19898;

   typedef logic [sopll_pkg::CSR_INDEX_W-1:0] csr_index_type;

   // arctan(2^-i) in 32-bit turns, one entry per CORDIC iteration
   localparam logic [31:0] ARCTAN_STEP [STEPS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
   };

   // corner samples: full scale on each axis, zero, off-by-one, alternating bits
   localparam int N_CORNERS = 18;
   localparam logic [15:0] CORNER_I [N_CORNERS] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF,
      16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000,
      16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h8000
   };
   localparam logic [15:0] CORNER_Q [N_CORNERS] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF,
      16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0001,
      16'hFFFF, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0001
   };

   typedef struct {
      logic signed [15:0] out_i;
      logic signed [15:0] out_q;
      logic signed [31:0] loop_error;
      logic signed [31:0] freq_estimate;
   } loop_output_type;

   // Tracks the oscillator phase and frequency and holds the outputs still due.
   class loop_tracker_type;
      logic [31:0]        osc_phase;
      logic signed [31:0] osc_freq;
      logic [15:0]        phase_gain;
      logic [15:0]        freq_gain;
      loop_output_type    outputs_due[$];
      int                 errors;

      function new();
         osc_phase  = '0;
         osc_freq   = '0;
         phase_gain = sopll_pkg::PHASE_GAIN_RESET;
         freq_gain  = sopll_pkg::FREQ_GAIN_RESET;
         errors     = 0;
      endfunction

      function void write_gain(input csr_index_type index, input logic [15:0] value);
         case (index)
            sopll_pkg::CSR_PHASE_GAIN: phase_gain = value;
            sopll_pkg::CSR_FREQ_GAIN:  freq_gain = value;
            default: ;
         endcase
      endfunction

      // cos/sin of the phase truncated to the table resolution
      function void oscillator_point(input logic [31:0] p, output logic signed [15:0] c,
                                     output logic signed [15:0] s);
         logic [31:0] q;
         longint      z;
         longint      x;
         longint      y;
         longint      dx;
         longint      dy;
         bit          flip;
         q    = p & ~((32'd1 << (32 - TABLE_BITS)) - 32'd1);
         z    = q[31] ? longint'(q) - 64'sd4294967296 : longint'(q);
         x    = UNIT_AMPLITUDE;
         y    = 0;
         flip = 1'b0;
         if (z > (64'sd1 <<< 30)) begin
            z    = z - (64'sd1 <<< 31);
            flip = 1'b1;
         end else if (z < -(64'sd1 <<< 30)) begin
            z    = z + (64'sd1 <<< 31);
            flip = 1'b1;
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - longint'(ARCTAN_STEP[i]);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + longint'(ARCTAN_STEP[i]);
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = (x > 32767) ? 16'sh7FFF : (x < -32768) ? 16'sh8000 : x[15:0];
         s = (y > 32767) ? 16'sh7FFF : (y < -32768) ? 16'sh8000 : y[15:0];
      endfunction

      // angle of (x, y) in 32-bit turns; the origin measures as zero
      function logic [31:0] sample_angle(input longint x, input longint y);
         logic [31:0] z;
         longint      dx;
         longint      dy;
         z = '0;
         if (x == 0 && y == 0) begin
            return '0;
         end
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + ARCTAN_STEP[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - ARCTAN_STEP[i];
            end
         end
         return z;
      endfunction

      function void note_sample(input logic signed [15:0] in_i, input logic signed [15:0] in_q);
         loop_output_type    r;
         logic [31:0]        meas;
         logic signed [31:0] diff;
         longint             err;
         longint             nf;
         longint             padj;
         oscillator_point(osc_phase, r.out_i, r.out_q);
         meas = sample_angle(longint'(in_i), longint'(in_q));
         diff = meas - osc_phase;
         err  = diff;
         nf   = longint'(osc_freq) + ((longint'(freq_gain) * err) >>> 24);
         if (nf > longint'(FREQ_MAX)) begin
            nf = FREQ_MAX;
         end else if (nf < longint'(FREQ_MIN)) begin
            nf = FREQ_MIN;
         end
         padj      = (longint'(phase_gain) * err) >>> 16;
         osc_freq  = nf[31:0];
         osc_phase = osc_phase + padj[31:0] + nf[31:0];
         r.loop_error    = diff;
         r.freq_estimate = nf[31:0];
         outputs_due.push_back(r);
      endfunction

      function void compare_field(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      function void check_output(input logic [95:0] data);
         loop_output_type want;
         if (outputs_due.size() == 0) begin
            errors++;
            $display("%0t: result %h with nothing expected", $time, data);
            return;
         end
         want = outputs_due.pop_front();
         compare_field("out_i", 32'(want.out_i), 32'($signed(data[15:0])));
         compare_field("out_q", 32'(want.out_q), 32'($signed(data[31:16])));
         compare_field("loop_error", want.loop_error, data[63:32]);
         compare_field("freq_estimate", want.freq_estimate, data[95:64]);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;   // in_i[15:0], in_q[31:16]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [95:0]            rsp_tdata;   // out_i, out_q, loop_error, freq_estimate
   logic                   csr_valid;
   logic                   csr_ready;
   csr_index_type          csr_index;
   logic [15:0]            csr_data;

   // checker side sees accepted handshakes; stimulus side runs ahead to aim samples
   loop_tracker_type checker_model = new;
   loop_tracker_type stim_model    = new;

   int          gap_percent     = 0;
   int          stall_percent   = 0;
   int          hold_off_cycles = 0;
   int unsigned cycle_count     = 0;

   second_order_phase_locked_loop #(
      .CORDIC_STEPS   (STEPS),
      .SINE_TABLE_BITS(TABLE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watch all three channels; every sample accepted queues one expected item.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            checker_model.write_gain(csr_index, csr_data);
         end
         if (req_tvalid && req_tready) begin
            checker_model.note_sample(req_tdata[15:0], req_tdata[31:16]);
         end
         if (rsp_tvalid && rsp_tready) begin
            checker_model.check_output(rsp_tdata);
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request so the
   // pipeline fills and pushes back on the sample side.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < stall_percent) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one sample and hold it until accepted; valid stays high afterwards.
   task automatic send_sample(input logic [15:0] in_i, input logic [15:0] in_q);
      if ($urandom_range(0, 99) < gap_percent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {in_q, in_i};
      stim_model.note_sample(in_i, in_q);
      stim_model.outputs_due.delete();
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every expected item is back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (checker_model.outputs_due.size() != 0) @(posedge clock);
   endtask

   // Keep valid high across a burst of writes; drop it after the last one.
   task automatic write_register(input csr_index_type index,
                                 input logic [15:0] value, input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      stim_model.write_gain(index, value);
      do @(posedge clock); while (!csr_ready);
      if (last) begin
         csr_valid <= 1'b0;
      end
   endtask

   task automatic set_gains(input logic [15:0] pg, input logic [15:0] fg);
      write_register(sopll_pkg::CSR_PHASE_GAIN, pg, 1'b0);
      write_register(sopll_pkg::CSR_FREQ_GAIN, fg, 1'b1);
   endtask

   // Rotating tone of random rate and amplitude, with small noise; about one
   // sample in ten is replaced by an arbitrary word.
   task automatic send_tone(input int count);
      logic [31:0]        ph;
      logic [31:0]        step;
      logic signed [15:0] c;
      logic signed [15:0] s;
      int                 shift;
      ph    = $urandom;
      step  = $urandom_range(0, 32'h01000000);
      shift = $urandom_range(0, 10);
      if ($urandom_range(0, 1) == 1) begin
         step = -step;
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_sample(16'($urandom), 16'($urandom));
         end else begin
            stim_model.oscillator_point(ph, c, s);
            send_sample(16'((int'(c) >>> shift) + int'($urandom_range(0, 6)) - 3),
                        16'((int'(s) >>> shift) + int'($urandom_range(0, 6)) - 3));
         end
         ph = ph + step;
      end
   endtask

   // Aim each sample nearly a half turn ahead of (or behind) the oscillator so
   // the error keeps one sign and the frequency runs into its limit; then
   // dwell there a few samples.
   task automatic chase_limit(input bit upward);
      logic [31:0]        offset;
      logic [31:0]        target;
      logic signed [15:0] c;
      logic signed [15:0] s;
      int                 shift;
      int                 dwell;
      dwell = 0;
      while (dwell < 6) begin
         if (stim_model.osc_freq == (upward ? FREQ_MAX : FREQ_MIN)) begin
            dwell++;
         end
         offset = $urandom_range(32'h78000000, 32'h7E000000);
         target = upward ? stim_model.osc_phase + offset : stim_model.osc_phase - offset;
         shift  = $urandom_range(0, 4);
         stim_model.oscillator_point(target, c, s);
         send_sample(16'(c >>> shift), 16'(s >>> shift));
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= sopll_pkg::CSR_PHASE_GAIN;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // an unused index must leave both gains alone
      write_register(csr_index_type'(sopll_pkg::CSR_FREQ_GAIN + 1 + $urandom_range(0, 13)),
                     16'($urandom), 1'b1);

      // corners at reset gains, back to back
      for (int k = 0; k < N_CORNERS; k++) begin
         send_sample(CORNER_I[k], CORNER_Q[k]);
      end

      // tones at reset gains with idling on both sides and one long hold-off
      gap_percent     = 25;
      stall_percent   = 25;
      hold_off_cycles = 300;
      send_tone(170);
      drain();

      // zero gains: the frequency holds and the error no longer steers the oscillator
      set_gains(16'h0000, 16'h0000);
      gap_percent   = 50;
      stall_percent = 0;
      send_tone(40);
      drain();

      set_gains(16'($urandom), 16'($urandom));
      gap_percent   = 0;
      stall_percent = 50;
      send_tone(80);
      drain();

      // full gains: drive the frequency into one saturation limit, picked at random
      set_gains(16'hFFFF, 16'hFFFF);
      gap_percent   = 10;
      stall_percent = 10;
      chase_limit(1'($urandom_range(0, 1)));
      drain();

      // closing stretch at full rate, no idling
      set_gains(16'($urandom), 16'($urandom));
      gap_percent   = 0;
      stall_percent = 0;
      send_tone(60);
      drain();
      repeat (4 * PIPE_LATENCY) @(posedge clock);

      if (checker_model.errors == 0 && checker_model.outputs_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
